/* hdl/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared widths, constants and types of the ROM block cache front end.
// ----------------------------------------------------------------------------
`default_nettype none
package rbc_pkg;

  localparam int unsigned BLOCK_BYTES    = 65536;
  localparam int unsigned ROM_BLOCKS_MAX = 1024;
  localparam int unsigned CACHE_SLOTS    = 32;
  localparam int unsigned AGE_W          = 16;

  localparam int unsigned WITHIN_W = $clog2(BLOCK_BYTES);
  localparam int unsigned BLK_W    = $clog2(ROM_BLOCKS_MAX);
  localparam int unsigned SLOT_W   = $clog2(CACHE_SLOTS);
  localparam int unsigned MAP_W    = SLOT_W + 1;
  localparam int unsigned OFF_W    = 26;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned ROM_W    = 27;
  localparam int unsigned CADDR_W  = 21;

  localparam logic [AGE_W-1:0]  AGE_MAX     = '1;
  localparam logic [LEN_W-1:0]  BLOCK_LEN   = LEN_W'(BLOCK_BYTES);
  localparam logic [ROM_W-1:0]  CACHE_BYTES = ROM_W'(CACHE_SLOTS * BLOCK_BYTES);
  localparam logic [BLK_W-1:0]  BLK_LAST    = BLK_W'(ROM_BLOCKS_MAX - 1);

  // register byte addresses
  localparam logic [2:0] REG_ROM_SIZE = 3'd0;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOOK   = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_SWEEP  = 7'b0010000,
    S_FIXMAP = 7'b0100000,
    S_FIXNEW = 7'b1000000
  } state_t;

  // segment arithmetic results
  typedef struct packed {
    logic [LEN_W-1:0] seg_len;
    logic [LEN_W-1:0] load_len;
  } seg_info_t;

endpackage
`default_nettype wire

/* hdl/rbc_ram.sv */
// ----------------------------------------------------------------------------
// rbc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/rbc_seg.sv */
// ----------------------------------------------------------------------------
// rbc_seg
// Segment length and ROM load length for the block currently handled.
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_seg (
  input  wire logic [rbc_pkg::BLK_W-1:0]    blk,
  input  wire logic [rbc_pkg::WITHIN_W-1:0] blk_off,
  input  wire logic [rbc_pkg::LEN_W-1:0]    rem_len,
  input  wire logic [rbc_pkg::ROM_W-1:0]    rom_size,
  output rbc_pkg::seg_info_t                info
);
  import rbc_pkg::*;

  logic [LEN_W-1:0] room;
  logic [ROM_W-1:0] blk_start;
  logic [ROM_W-1:0] tail;

  // bytes left in this block from the start position
  assign room = BLOCK_LEN - LEN_W'(blk_off);
  assign info.seg_len = (rem_len > room) ? room : rem_len;

  // load length, short for the final block, zero past the end
  assign blk_start = ROM_W'({blk, {WITHIN_W{1'b0}}});
  assign tail      = rom_size - blk_start;
  always_comb begin
    if (blk_start >= rom_size) begin
      info.load_len = '0;
    end else if (tail < ROM_W'(BLOCK_BYTES)) begin
      info.load_len = LEN_W'(tail);
    end else begin
      info.load_len = BLOCK_LEN;
    end
  end

endmodule
`default_nettype wire

/* hdl/rom_block_cache_lru.sv */
// ----------------------------------------------------------------------------
// rom_block_cache_lru
// Fully associative LRU block cache front end for a ROM.
// ----------------------------------------------------------------------------
// A request word (start_offset, read_length) is taken when start is high and
// busy is low. It is split into at most two block segments, each shown on the
// result ports for one cycle with valid high; the receiver cannot stall.
// rom_size is to be written over the APB port only while the block is idle;
// the block itself does not enforce this. Direct mode (rom_size fits the
// cache): the single segment appears the cycle after acceptance and busy
// stays low. Caching mode: for each segment the LOOK and CHECK states read
// the map entry, a sweep of all 1024 block entries runs through the age
// and map memories (one entry per cycle, ageing every block and searching
// for the oldest resident one), and FIXMAP and FIXNEW evict and install.
// The age sweep over the memory read port sets how long busy stays high.
// A zero read_length gives no segment.
// After reset a clearing pass over every block entry loads the initial map
// and ages; busy is high meanwhile, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
`default_nettype none
module rom_block_cache_lru (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // apb configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // request
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rbc_pkg::OFF_W-1:0]     start_offset,
  input  wire logic [rbc_pkg::LEN_W-1:0]     read_length,
  // result
  output logic                               valid,
  output logic      [rbc_pkg::BLK_W-1:0]     seg_block,
  output logic      [rbc_pkg::CADDR_W-1:0]   cache_address,
  output logic      [rbc_pkg::LEN_W-1:0]     seg_length,
  output logic                               miss,
  output logic      [rbc_pkg::LEN_W-1:0]     load_length,
  output logic      [rbc_pkg::BLK_W-1:0]     evicted_block,
  output logic                               last
);
  import rbc_pkg::*;

  state_t state;

  logic [ROM_W-1:0]    rom_size;
  logic [BLK_W-1:0]    cur_blk;
  logic [WITHIN_W-1:0] blk_off;
  logic [LEN_W-1:0]    rem_len;
  logic [LEN_W-1:0]    len_sat;
  logic [LEN_W-1:0]    rem_next;

  logic [BLK_W-1:0]    clr_addr;
  logic [BLK_W-1:0]    sweep_addr;
  logic                iss_on;
  logic                pipe_v;
  logic [BLK_W-1:0]    pipe_addr;

  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic                found;
  logic [AGE_W-1:0]    best_age;
  logic [BLK_W-1:0]    best_idx;
  logic [SLOT_W-1:0]   best_slot;
  logic [SLOT_W-1:0]   use_slot;
  logic [BLK_W-1:0]    ev_blk;

  logic                map_we;
  logic [BLK_W-1:0]    map_waddr;
  logic [MAP_W-1:0]    map_wdata;
  logic [BLK_W-1:0]    map_raddr;
  logic [MAP_W-1:0]    map_q;
  logic                age_we;
  logic [BLK_W-1:0]    age_waddr;
  logic [AGE_W-1:0]    age_wdata;
  logic [AGE_W-1:0]    age_q;
  logic                accept;
  logic                cfg_wr;
  seg_info_t           seg;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == REG_ROM_SIZE) ? 32'(rom_size) : '0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size <= '0;
    end else if (cfg_wr && paddr == REG_ROM_SIZE) begin
      rom_size <= pwdata[ROM_W-1:0];
    end
  end

  assign len_sat = (read_length > BLOCK_LEN) ? BLOCK_LEN : read_length;

  rbc_seg u_seg (
    .blk      (cur_blk),
    .blk_off  (blk_off),
    .rem_len  (rem_len),
    .rom_size (rom_size),
    .info     (seg)
  );

  assign rem_next = rem_len - seg.seg_len;
  assign use_slot = hit ? hit_slot : (found ? best_slot : '0);
  assign ev_blk   = (!hit && found) ? best_idx : '0;

  // memory port steering
  always_comb begin
    map_we    = 1'b0;
    map_waddr = cur_blk;
    map_wdata = {1'b1, use_slot};
    age_we    = 1'b0;
    age_waddr = cur_blk;
    age_wdata = '0;
    map_raddr = (state == S_LOOK) ? cur_blk : sweep_addr;
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = (32'(clr_addr) < CACHE_SLOTS) ? {1'b1, SLOT_W'(clr_addr)} : '0;
        age_we    = 1'b1;
        age_waddr = clr_addr;
        age_wdata = (32'(clr_addr) < 32'(AGE_MAX)) ? AGE_W'(clr_addr) : AGE_MAX;
      end
      S_SWEEP: begin
        age_we    = pipe_v;
        age_waddr = pipe_addr;
        age_wdata = (age_q == AGE_MAX) ? AGE_MAX : age_q + AGE_W'(1);
      end
      S_FIXMAP: begin
        map_we    = !hit && found;
        map_waddr = best_idx;
        map_wdata = '0;
      end
      S_FIXNEW: begin
        map_we = 1'b1;
        age_we = 1'b1;
      end
      default: ;
    endcase
  end

  rbc_ram #(.DEPTH(ROM_BLOCKS_MAX), .WIDTH(MAP_W)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  rbc_ram #(.DEPTH(ROM_BLOCKS_MAX), .WIDTH(AGE_W)) u_age (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (sweep_addr),
    .rdata (age_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      iss_on   <= 1'b0;
      pipe_v   <= 1'b0;
      valid    <= 1'b0;
    end else begin
      valid  <= 1'b0;
      pipe_v <= iss_on;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BLK_W'(1);
          if (clr_addr == BLK_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && read_length != '0) begin
            if (rom_size <= CACHE_BYTES) begin
              valid <= 1'b1;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          iss_on <= 1'b1;
          state  <= S_SWEEP;
        end
        S_SWEEP: begin
          if (sweep_addr == BLK_LAST) begin
            iss_on <= 1'b0;
          end
          if (pipe_v && pipe_addr == BLK_LAST) begin
            state <= S_FIXMAP;
          end
        end
        S_FIXMAP: begin
          state <= S_FIXNEW;
        end
        S_FIXNEW: begin
          valid <= 1'b1;
          state <= (rem_next == '0) ? S_IDLE : S_LOOK;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // request, scan and result data
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cur_blk       <= start_offset[OFF_W-1:WITHIN_W];
      blk_off       <= start_offset[WITHIN_W-1:0];
      rem_len       <= len_sat;
      seg_block     <= start_offset[OFF_W-1:WITHIN_W];
      cache_address <= start_offset[CADDR_W-1:0];
      seg_length    <= len_sat;
      miss          <= 1'b0;
      load_length   <= '0;
      evicted_block <= '0;
      last          <= 1'b1;
    end
    if (state == S_CHECK) begin
      hit        <= map_q[MAP_W-1];
      hit_slot   <= map_q[SLOT_W-1:0];
      found      <= 1'b0;
      sweep_addr <= '0;
    end
    // address issue for the sweep
    if (iss_on && sweep_addr != BLK_LAST) begin
      sweep_addr <= sweep_addr + BLK_W'(1);
    end
    pipe_addr <= sweep_addr;
    // oldest resident block, lowest index on ties
    if (state == S_SWEEP && pipe_v && map_q[MAP_W-1] && (!found || age_q > best_age)) begin
      found     <= 1'b1;
      best_age  <= age_q;
      best_idx  <= pipe_addr;
      best_slot <= map_q[SLOT_W-1:0];
    end
    if (state == S_FIXNEW) begin
      seg_block     <= cur_blk;
      cache_address <= {use_slot, blk_off};
      seg_length    <= seg.seg_len;
      miss          <= !hit;
      load_length   <= hit ? '0 : seg.load_len;
      evicted_block <= ev_blk;
      last          <= (rem_next == '0);
      rem_len       <= rem_next;
      cur_blk       <= cur_blk + BLK_W'(1);
      blk_off       <= '0;
    end
  end

endmodule
`default_nettype wire

/* hdl/rbc_chk.sv */
// ----------------------------------------------------------------------------
// rbc_chk
// Port-level checks of the ROM block cache front end, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [rbc_pkg::LEN_W-1:0]   read_length,
  input wire logic                        valid,
  input wire logic [rbc_pkg::LEN_W-1:0]   seg_length,
  input wire logic                        miss,
  input wire logic [rbc_pkg::LEN_W-1:0]   load_length,
  input wire logic [rbc_pkg::BLK_W-1:0]   evicted_block,
  input wire logic                        last
);

  // a segment always carries bytes
  a_seg_len: assert property (@(posedge clk) disable iff (rst)
    valid |-> seg_length != '0) else $error("empty segment");

  // hits report no load order
  a_hit: assert property (@(posedge clk) disable iff (rst)
    valid && !miss |-> load_length == '0 && evicted_block == '0)
    else $error("hit with load order");

  // the final segment frees the request side
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy) else $error("busy during final segment");

  // a first segment keeps the block busy for the second
  a_more: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> busy) else $error("idle between segments");

  // an empty request gives no word
  a_empty: assert property (@(posedge clk) disable iff (rst)
    start && !busy && read_length == '0 |=> !valid) else $error("word for empty request");

endmodule

bind rom_block_cache_lru rbc_chk u_rbc_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .read_length   (read_length),
  .valid         (valid),
  .seg_length    (seg_length),
  .miss          (miss),
  .load_length   (load_length),
  .evicted_block (evicted_block),
  .last          (last)
);
`default_nettype wire

/* test/tb_rom_block_cache_lru.sv */
// ----------------------------------------------------------------------------
// tb_rom_block_cache_lru
// Self-checking bench for the LRU ROM block cache front end.
// ----------------------------------------------------------------------------
// Requests are sent with random gaps, and the bench predicts every segment
// word from its own copy of the block map, the ages and rom_size. Each segment
// that the block shows is compared field by field with the oldest prediction.
// rom_size is changed over APB only while the block is idle, apart from the
// first write, in the clearing pass after reset. The run covers direct mode,
// a ROM just over the cache size, the largest ROM and random sizes.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rom_block_cache_lru;
  timeunit 1ns;
  timeprecision 1ps;
  import rbc_pkg::*;

  typedef struct {
    logic [BLK_W-1:0]   blk;
    logic [CADDR_W-1:0] caddr;
    logic [LEN_W-1:0]   seg_len;
    logic               seg_miss;
    logic [LEN_W-1:0]   load_len;
    logic [BLK_W-1:0]   ev_blk;
    logic               seg_last;
  } segment_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [OFF_W-1:0]  start_offset = '0;
  logic [LEN_W-1:0]  read_length = '0;
  logic              valid;
  logic [BLK_W-1:0]  seg_block;
  logic [CADDR_W-1:0] cache_address;
  logic [LEN_W-1:0]  seg_length;
  logic              miss;
  logic [LEN_W-1:0]  load_length;
  logic [BLK_W-1:0]  evicted_block;
  logic              last;

  // predictor state
  logic [ROM_W-1:0]  rom_bytes;
  logic              blk_resident [ROM_BLOCKS_MAX];
  logic [SLOT_W-1:0] blk_slot [ROM_BLOCKS_MAX];
  logic [AGE_W-1:0]  blk_age [ROM_BLOCKS_MAX];
  segment_t          pending_segs [$];
  int                errors = 0;

  rom_block_cache_lru dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .start_offset(start_offset),
    .read_length(read_length),
    .valid(valid), .seg_block(seg_block), .cache_address(cache_address),
    .seg_length(seg_length), .miss(miss), .load_length(load_length),
    .evicted_block(evicted_block), .last(last)
  );

  always #5 clk = ~clk;

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // reset state of the map and ages
  function automatic void reset_model();
    rom_bytes = '0;
    for (int i = 0; i < ROM_BLOCKS_MAX; i++) begin
      blk_resident[i] = (i < CACHE_SLOTS);
      blk_slot[i]     = (i < CACHE_SLOTS) ? SLOT_W'(i) : '0;
      blk_age[i]      = (i < int'(AGE_MAX)) ? AGE_W'(i) : AGE_MAX;
    end
  endfunction

  // segments of one request, updating map and ages
  function automatic void split_request(logic [OFF_W-1:0] off, logic [LEN_W-1:0] len_in);
    logic [LEN_W-1:0]  remaining;
    logic [BLK_W-1:0]  blk;
    logic [LEN_W-1:0]  blk_off;
    logic [LEN_W-1:0]  seg;
    logic [BLK_W-1:0]  victim;
    logic [SLOT_W-1:0] slot;
    logic              found;
    longint            blk_start;
    segment_t          s;
    remaining = len_in;
    if (remaining == 0) return;
    if (remaining > BLOCK_LEN) remaining = BLOCK_LEN;
    if (rom_bytes <= CACHE_BYTES) begin
      s = '{off[OFF_W-1:WITHIN_W], off[CADDR_W-1:0], remaining, 1'b0, '0, '0, 1'b1};
      pending_segs.push_back(s);
      return;
    end
    blk = off[OFF_W-1:WITHIN_W];
    blk_off = {1'b0, off[WITHIN_W-1:0]};
    for (int n = 0; n < 2 && remaining != 0; n++) begin
      s.seg_miss = 1'b0;
      s.load_len = '0;
      s.ev_blk = '0;
      if (blk_resident[blk]) begin
        slot = blk_slot[blk];
      end else begin
        // oldest resident block, lowest index on ties
        found = 1'b0;
        victim = '0;
        slot = '0;
        for (int i = 0; i < ROM_BLOCKS_MAX; i++)
          if (blk_resident[i] && (!found || blk_age[i] > blk_age[victim])) begin
            victim = BLK_W'(i);
            found = 1'b1;
          end
        if (found) begin
          slot = blk_slot[victim];
          blk_resident[victim] = 1'b0;
          s.ev_blk = victim;
        end
        blk_resident[blk] = 1'b1;
        blk_slot[blk] = slot;
        blk_start = longint'(blk) * BLOCK_BYTES;
        if (blk_start >= longint'(rom_bytes)) s.load_len = '0;
        else if (blk_start + BLOCK_BYTES > longint'(rom_bytes))
          s.load_len = LEN_W'(longint'(rom_bytes) - blk_start);
        else s.load_len = BLOCK_LEN;
        s.seg_miss = 1'b1;
      end
      seg = (remaining > BLOCK_LEN - blk_off) ? BLOCK_LEN - blk_off : remaining;
      for (int i = 0; i < ROM_BLOCKS_MAX; i++)
        if (blk_age[i] < AGE_MAX) blk_age[i]++;
      blk_age[blk] = '0;
      remaining -= seg;
      s.blk = blk;
      s.caddr = CADDR_W'({slot, 16'h0}) + CADDR_W'(blk_off);
      s.seg_len = seg;
      s.seg_last = (remaining == 0);
      pending_segs.push_back(s);
      blk = blk + 1'b1;
      blk_off = '0;
    end
  endfunction

  // segment word checker
  always @(posedge clk) begin
    segment_t e;
    if (!rst && valid) begin
      if (pending_segs.size() == 0) begin
        $display("%0t: unexpected segment blk %0d addr %0h", $time, seg_block, cache_address);
        errors++;
      end else begin
        e = pending_segs.pop_front();
        if (seg_block !== e.blk) begin
          $display("%0t: seg_block exp %0d got %0d", $time, e.blk, seg_block); errors++;
        end
        if (cache_address !== e.caddr) begin
          $display("%0t: cache_address exp %0h got %0h", $time, e.caddr, cache_address);
          errors++;
        end
        if (seg_length !== e.seg_len) begin
          $display("%0t: seg_length exp %0d got %0d", $time, e.seg_len, seg_length); errors++;
        end
        if (miss !== e.seg_miss) begin
          $display("%0t: miss exp %0b got %0b", $time, e.seg_miss, miss); errors++;
        end
        if (load_length !== e.load_len) begin
          $display("%0t: load_length exp %0d got %0d", $time, e.load_len, load_length);
          errors++;
        end
        if (evicted_block !== e.ev_blk) begin
          $display("%0t: evicted_block exp %0d got %0d", $time, e.ev_blk, evicted_block);
          errors++;
        end
        if (last !== e.seg_last) begin
          $display("%0t: last exp %0b got %0b", $time, e.seg_last, last); errors++;
        end
      end
    end
  end

  // present one request word and hold it until taken
  task automatic send_request(logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
    start <= 1'b1;
    start_offset <= off;
    read_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    split_request(off, len);
  endtask

  // random gap after a word, mostly short
  task automatic sender_gap(bit no_idle);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (no_idle || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_segs.size() != 0 || busy) @(posedge clk);
    repeat (2100) @(posedge clk);
  endtask

  task automatic write_rom_size(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ROM_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rom_bytes = value[ROM_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // random request, mostly near a small pool of blocks so hits occur
  task automatic random_request();
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    int r;
    r = $urandom_range(0, 99);
    off = OFF_W'($urandom);
    if (r < 70) off[OFF_W-1:WITHIN_W] = BLK_W'($urandom_range(0, 47));
    r = $urandom_range(0, 99);
    if (r < 55) len = LEN_W'($urandom_range(1, 4096));
    else if (r < 85) len = LEN_W'($urandom_range(1, BLOCK_BYTES));
    else if (r < 95) len = LEN_W'($urandom);
    else len = '0;
    send_request(off, len);
  endtask

  task automatic random_burst(int count);
    bit no_idle;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_request();
      sender_gap(no_idle);
    end
  endtask

  // direct mode: fields extremes, zero and overlong lengths
  task automatic test_direct_mode();
    write_rom_size(32'd0);
    send_request('0, 17'd1);
    send_request('1, 17'd65536);
    send_request(26'h0123456, '0);
    send_request(26'h2aaaaaa, '1);
    send_request(26'h155ffff, 17'd2);
    sender_gap(1'b0);
    random_burst(40);
    wait_idle();
    write_rom_size(32'(CACHE_BYTES));
    send_request(26'h3ff0001, 17'd65537);
    random_burst(30);
    wait_idle();
  endtask

  // caching mode with a ROM one byte over the cache: short final block
  task automatic test_short_rom();
    write_rom_size(32'(CACHE_BYTES) + 32'd1);
    send_request(26'h0000010, 17'd32);
    send_request(26'h01fff00, 17'd512);
    send_request(26'h0210000, 17'd16);
    send_request(26'h0220000, 17'd1);
    send_request(26'h0000000, '0);
    sender_gap(1'b0);
    random_burst(100);
    wait_idle();
  endtask

  // largest rom, block wrap past the top and overlong requests
  task automatic test_large_rom();
    write_rom_size(32'h0400_0000);
    send_request('1, 17'd2);
    send_request(26'h3ffffff, '1);
    send_request(26'h0050000, 17'd65536);
    send_request(26'h005ffff, 17'd65536);
    send_request(26'h0050000, 17'd100);
    random_burst(120);
    wait_idle();
    write_rom_size(32'hffff_ffff);
    random_burst(60);
    wait_idle();
  endtask

  task automatic test_random_sizes();
    for (int k = 0; k < 3; k++) begin
      write_rom_size($urandom_range(32'(CACHE_BYTES) + 1, 32'h0400_0000));
      random_burst(50);
      wait_idle();
    end
    write_rom_size($urandom_range(0, 32'(CACHE_BYTES)));
    random_burst(30);
    wait_idle();
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_direct_mode();
    test_short_rom();
    test_large_rom();
    test_random_sizes();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hdl/rbc_pkg.sv
hdl/rbc_ram.sv
hdl/rbc_seg.sv
hdl/rom_block_cache_lru.sv
hdl/rbc_chk.sv
test/tb_rom_block_cache_lru.sv
